// ===== hw/rtl/lpd_pkg.sv =====
// Shared types, constants and helper functions of the lattice diffusion block.
package lpd_pkg;

   localparam int unsigned COORD_W     = 3;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned CELL_W      = 16;
   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 16;
   localparam int unsigned SEED_W      = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned TW_N     = 624;
   localparam int unsigned TW_M     = 397;
   localparam int unsigned TW_IDX_W = 10;
   localparam logic [TW_IDX_W-1:0] TW_LAST   = TW_IDX_W'(TW_N - 1);
   localparam logic [TW_IDX_W-1:0] TW_BACK   = TW_IDX_W'(TW_N - TW_M);
   localparam logic [TW_IDX_W-1:0] TW_AHEAD  = TW_IDX_W'(TW_M);
   localparam logic [31:0] TW_MATRIX    = 32'h9908_B0DF;
   localparam logic [31:0] TW_INIT_MULT = 32'd1812433253;
   localparam logic [31:0] SEED_RESET   = 32'd5489;
   localparam logic [35:0] DRAW_SPAN    = 36'h0_FFFF_FFFF;

   typedef enum logic {
      MODE_DIFFUSE = 1'b0,
      MODE_READ    = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      DIR_XM   = 3'd0,
      DIR_XP   = 3'd1,
      DIR_YM   = 3'd2,
      DIR_YP   = 3'd3,
      DIR_ZM   = 3'd4,
      DIR_ZP   = 3'd5,
      DIR_SELF = 3'd6
   } dir_type;

   typedef struct packed {
      mode_type             mode;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COORD_W-1:0]   z;
      logic [COUNT_W-1:0]   count;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] word;
   } rng_rsp_type;

   typedef enum logic [2:0] {
      TW_START,
      TW_SEED_MUL,
      TW_SEED_ADD,
      TW_IDLE,
      TW_READ,
      TW_GEN
   } tw_state_type;

   typedef enum logic [2:0] {
      EN_CLEAR,
      EN_IDLE,
      EN_DRAW,
      EN_ADDR,
      EN_FETCH,
      EN_WRITE,
      EN_REPLY
   } en_state_type;

   function automatic logic [31:0] temper(input logic [31:0] v);
      logic [31:0] y;
      y = v ^ (v >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // floor(12*r / (2^32-1)), with every value of six or more meaning the cell itself.
   function automatic dir_type dir_of(input logic [31:0] r);
      logic [35:0] t;
      dir_type     d;
      t = ({4'b0, r} << 3) + ({4'b0, r} << 2);
      if (t >= 36'd6 * DRAW_SPAN) d = DIR_SELF;
      else if (t >= 36'd5 * DRAW_SPAN) d = DIR_ZP;
      else if (t >= 36'd4 * DRAW_SPAN) d = DIR_ZM;
      else if (t >= 36'd3 * DRAW_SPAN) d = DIR_YP;
      else if (t >= 36'd2 * DRAW_SPAN) d = DIR_YM;
      else if (t >= DRAW_SPAN) d = DIR_XP;
      else d = DIR_XM;
      return d;
   endfunction

endpackage

// ===== hw/rtl/lpd_front.sv =====
// Front end: unpacks request transactions and clamps the coordinates into the grid.
module lpd_front #(
   parameter int GRID_SIZE = 8
) (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lpd_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  logic                                store_ready,
   output logic                                push_valid,
   output lpd_pkg::cmd_type                    push_cmd,
   input  logic                                push_ready
);

   function automatic logic [lpd_pkg::COORD_W-1:0] clamp(
      input logic [lpd_pkg::COORD_W-1:0] c
   );
      logic [lpd_pkg::COORD_W-1:0] r;
      r = c;
      if (32'(c) >= 32'(GRID_SIZE)) r = lpd_pkg::COORD_W'(GRID_SIZE - 1);
      return r;
   endfunction

   always_comb begin
      push_cmd.mode  = lpd_pkg::mode_type'(req_tuser);
      push_cmd.x     = clamp(req_tdata[2:0]);
      push_cmd.y     = clamp(req_tdata[5:3]);
      push_cmd.z     = clamp(req_tdata[8:6]);
      push_cmd.count = req_tdata[24:9];
   end

   // Nothing is taken while the store is still being cleared after reset.
   assign req_tready = push_ready && store_ready;
   assign push_valid = req_tvalid && store_ready;

endmodule

// ===== hw/rtl/lpd_fifo.sv =====
// Short command queue between the front end and the engine.
module lpd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lpd_pkg::cmd_type  push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output lpd_pkg::cmd_type  pop_cmd,
   input  logic              pop_ready
);

   localparam int unsigned PTR_W = $clog2(lpd_pkg::QUEUE_DEPTH);

   lpd_pkg::cmd_type   entries_ff [lpd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != (PTR_W+1)'(lpd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ===== hw/rtl/lpd_twister.sv =====
// MT19937 generator: seeding pass and one regenerated, tempered word per draw.
module lpd_twister (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          seed_load,
   input  logic [lpd_pkg::SEED_W-1:0]    seed_value,
   input  logic                          draw_req,
   output lpd_pkg::rng_rsp_type          rng
);

   lpd_pkg::tw_state_type state_ff, state_in;

   logic [31:0] words [lpd_pkg::TW_N];
   logic [31:0] word_a_ff, word_b_ff;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] word_ff, word_in;
   logic        valid_ff, valid_in;
   logic [lpd_pkg::TW_IDX_W-1:0] widx_ff, widx_in;
   logic [lpd_pkg::TW_IDX_W-1:0] widx_next;
   logic [lpd_pkg::TW_IDX_W-1:0] rd_a, rd_b;
   logic [lpd_pkg::TW_IDX_W-1:0] mem_wa;
   logic [31:0] mem_wd;
   logic        mem_we;
   logic [31:0] gen_y, gen_v, mix;

   assign widx_next = (widx_ff == lpd_pkg::TW_LAST) ? '0 : widx_ff + 1'b1;
   assign rd_a      = widx_next;
   assign rd_b      = (widx_ff >= lpd_pkg::TW_BACK) ? widx_ff - lpd_pkg::TW_BACK
                                                    : widx_ff + lpd_pkg::TW_AHEAD;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpd_pkg::TW_START:    state_in = lpd_pkg::TW_SEED_MUL;
         lpd_pkg::TW_SEED_MUL: state_in = lpd_pkg::TW_SEED_ADD;
         lpd_pkg::TW_SEED_ADD: begin
            state_in = (widx_ff == lpd_pkg::TW_LAST) ? lpd_pkg::TW_IDLE
                                                     : lpd_pkg::TW_SEED_MUL;
         end
         lpd_pkg::TW_IDLE: begin
            if (draw_req && !valid_ff) state_in = lpd_pkg::TW_READ;
         end
         lpd_pkg::TW_READ:     state_in = lpd_pkg::TW_GEN;
         lpd_pkg::TW_GEN:      state_in = lpd_pkg::TW_IDLE;
         default:              state_in = lpd_pkg::TW_START;
      endcase
      if (seed_load) state_in = lpd_pkg::TW_START;
   end

   always_comb begin
      seed_in  = seed_load ? seed_value : seed_ff;
      p_in     = p_ff;
      prod_in  = prod_ff;
      cur_in   = cur_ff;
      widx_in  = widx_ff;
      word_in  = word_ff;
      valid_in = (state_ff == lpd_pkg::TW_GEN) && !seed_load;
      mem_we   = 1'b0;
      mem_wa   = widx_ff;
      mem_wd   = prod_ff + 32'(widx_ff);
      mix      = p_ff ^ {30'b0, p_ff[31:30]};
      gen_y    = {cur_ff[31], word_a_ff[30:0]};
      gen_v    = word_b_ff ^ {1'b0, gen_y[31:1]} ^ (gen_y[0] ? lpd_pkg::TW_MATRIX : 32'h0);
      unique case (state_ff)
         lpd_pkg::TW_START: begin
            mem_we  = 1'b1;
            mem_wa  = '0;
            mem_wd  = seed_ff;
            p_in    = seed_ff;
            cur_in  = seed_ff;
            widx_in = lpd_pkg::TW_IDX_W'(1);
         end
         lpd_pkg::TW_SEED_MUL: begin
            prod_in = lpd_pkg::TW_INIT_MULT * mix;
         end
         lpd_pkg::TW_SEED_ADD: begin
            mem_we  = 1'b1;
            p_in    = mem_wd;
            widx_in = widx_next;
         end
         lpd_pkg::TW_IDLE: begin
         end
         lpd_pkg::TW_READ: begin
         end
         lpd_pkg::TW_GEN: begin
            // Word i is regenerated in place; word i+1 is still the old one and
            // becomes the current word of the next draw.
            mem_we  = 1'b1;
            mem_wd  = gen_v;
            cur_in  = word_a_ff;
            word_in = lpd_pkg::temper(gen_v);
            widx_in = widx_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpd_pkg::TW_START;
         seed_ff  <= lpd_pkg::SEED_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      prod_ff <= prod_in;
      cur_ff  <= cur_in;
      widx_ff <= widx_in;
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) words[mem_wa] <= mem_wd;
      word_a_ff <= words[rd_a];
      word_b_ff <= words[rd_b];
   end

   assign rng.valid = valid_ff;
   assign rng.word  = word_ff;

endmodule

// ===== hw/rtl/lpd_engine.sv =====
// Back end: runs the draws, updates the cell store and holds the response register.
module lpd_engine #(
   parameter int GRID_SIZE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   input  lpd_pkg::cmd_type                   pop_cmd,
   output logic                               pop_ready,
   output logic                               store_ready,
   output logic                               draw_req,
   input  lpd_pkg::rng_rsp_type               rng,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lpd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int unsigned NW    = $clog2(GRID_SIZE);
   localparam int unsigned CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int unsigned AW    = $clog2(CELLS);
   localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
   localparam logic [AW-1:0] PLANE_SPAN  = AW'(GRID_SIZE * GRID_SIZE);
   localparam logic [AW-1:0] ROW_SPAN    = AW'(GRID_SIZE);
   localparam logic [NW-1:0] EDGE        = NW'(GRID_SIZE - 1);

   lpd_pkg::en_state_type state_ff, state_in;

   logic [lpd_pkg::CELL_W-1:0]  store [CELLS];
   logic [lpd_pkg::CELL_W-1:0]  store_q_ff;
   lpd_pkg::cmd_type            cmd_ff, cmd_in;
   lpd_pkg::dir_type            dir_ff, dir_in;
   logic [lpd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [lpd_pkg::CELL_W-1:0]  result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lpd_pkg::CELL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        mem_we;
   logic [AW-1:0]               mem_wa;
   logic [lpd_pkg::CELL_W-1:0]  mem_wd;
   logic [NW-1:0]               cx, cy, cz, nx, ny, nz;
   logic [AW-1:0]               nb_addr;
   logic                        reply_load;
   logic                        is_read;

   assign is_read    = (cmd_ff.mode == lpd_pkg::MODE_READ);
   assign reply_load = (state_ff == lpd_pkg::EN_REPLY) && (!rsp_valid_ff || rsp_tready);

   // Target cell of the current draw, clamped at the grid faces.
   always_comb begin
      cx = NW'(cmd_ff.x);
      cy = NW'(cmd_ff.y);
      cz = NW'(cmd_ff.z);
      nx = cx;
      ny = cy;
      nz = cz;
      unique case (dir_ff)
         lpd_pkg::DIR_XM:   if (cx != '0) nx = cx - 1'b1;
         lpd_pkg::DIR_XP:   if (cx < EDGE) nx = cx + 1'b1;
         lpd_pkg::DIR_YM:   if (cy != '0) ny = cy - 1'b1;
         lpd_pkg::DIR_YP:   if (cy < EDGE) ny = cy + 1'b1;
         lpd_pkg::DIR_ZM:   if (cz != '0) nz = cz - 1'b1;
         lpd_pkg::DIR_ZP:   if (cz < EDGE) nz = cz + 1'b1;
         lpd_pkg::DIR_SELF: begin
         end
         default: begin
         end
      endcase
      nb_addr = AW'(nx) * PLANE_SPAN + AW'(ny) * ROW_SPAN + AW'(nz);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpd_pkg::EN_CLEAR: begin
            if (clr_ff == LAST_CELL) state_in = lpd_pkg::EN_IDLE;
         end
         lpd_pkg::EN_IDLE: begin
            if (pop_valid) begin
               if (pop_cmd.mode == lpd_pkg::MODE_READ) state_in = lpd_pkg::EN_ADDR;
               else if (pop_cmd.count == '0) state_in = lpd_pkg::EN_REPLY;
               else state_in = lpd_pkg::EN_DRAW;
            end
         end
         lpd_pkg::EN_DRAW: begin
            if (rng.valid) state_in = lpd_pkg::EN_ADDR;
         end
         lpd_pkg::EN_ADDR:  state_in = lpd_pkg::EN_FETCH;
         lpd_pkg::EN_FETCH: state_in = lpd_pkg::EN_WRITE;
         lpd_pkg::EN_WRITE: begin
            if (is_read || count_ff == lpd_pkg::COUNT_W'(1)) state_in = lpd_pkg::EN_REPLY;
            else state_in = lpd_pkg::EN_DRAW;
         end
         lpd_pkg::EN_REPLY: begin
            if (reply_load) state_in = lpd_pkg::EN_IDLE;
         end
         default: state_in = lpd_pkg::EN_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      dir_in       = dir_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      result_in    = result_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = '0;
      pop_ready    = (state_ff == lpd_pkg::EN_IDLE);
      draw_req     = (state_ff == lpd_pkg::EN_DRAW);
      store_ready  = (state_ff != lpd_pkg::EN_CLEAR);
      unique case (state_ff)
         lpd_pkg::EN_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         lpd_pkg::EN_IDLE: begin
            if (pop_valid) begin
               cmd_in    = pop_cmd;
               count_in  = pop_cmd.count;
               dir_in    = lpd_pkg::DIR_SELF;
               result_in = '0;
            end
         end
         lpd_pkg::EN_DRAW: begin
            if (rng.valid) dir_in = lpd_pkg::dir_of(rng.word);
         end
         lpd_pkg::EN_ADDR: begin
            addr_in = nb_addr;
         end
         lpd_pkg::EN_FETCH: begin
         end
         lpd_pkg::EN_WRITE: begin
            mem_we = 1'b1;
            if (is_read) begin
               result_in = store_q_ff;
            end else begin
               mem_wd   = (store_q_ff == '1) ? store_q_ff : store_q_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         lpd_pkg::EN_REPLY: begin
            if (reply_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpd_pkg::EN_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      dir_ff      <= dir_in;
      count_ff    <= count_in;
      addr_ff     <= addr_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_wa] <= mem_wd;
      store_q_ff <= store[addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_word_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      rng.valid |-> state_ff == lpd_pkg::EN_DRAW)
      else $error("random word delivered while the engine was not drawing");

   a_update_has_particles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpd_pkg::EN_WRITE && cmd_ff.mode == lpd_pkg::MODE_DIFFUSE)
      |-> count_ff != '0)
      else $error("cell update issued with no particle left");

   a_diffuse_replies_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpd_pkg::EN_REPLY && cmd_ff.mode == lpd_pkg::MODE_DIFFUSE)
      |-> result_ff == '0)
      else $error("diffuse transaction would return a nonzero value");

endmodule

// ===== hw/rtl/lattice_particle_diffusion.sv =====
// Lattice particle diffusion: top level joining front end, queue, generator and engine.
//
// Requests arrive on req_*. req_tuser selects the operation: 0 diffuses the
// particles of one cell, 1 reads one accumulated cell and clears it. Every
// request transaction produces exactly one response transaction on rsp_*,
// carrying the cell value for a read and zero for a diffuse request.
// csr_* writes the generator seed; a write restarts the seeding pass.
// In a diffuse request of n particles, each particle takes one generator draw
// (read of two table words, then the in-place regeneration) followed by a
// read-modify-write of the cell store. Every request passes through the command
// queue before it reaches the engine. The seeding pass runs after reset or a
// seed write, and draws wait while it runs. After reset the cell store is
// cleared one cell per cycle, all GRID_SIZE**3 cells, and req_tready stays low
// meanwhile. The two-entry queue keeps accepting requests while the engine
// works, and the response register holds a result while rsp_tready is low,
// stalling the engine only when a second result is ready.
module lattice_particle_diffusion #(
   parameter int GRID_SIZE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x[2:0], pos_y[5:3], pos_z[8:6], particle_count[24:9], zero[31:25]
   input  logic [lpd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_value[15:0]
   output logic [lpd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpd_pkg::SEED_W-1:0]        csr_data
);

   logic                 push_valid, push_ready;
   lpd_pkg::cmd_type     push_cmd;
   logic                 pop_valid, pop_ready;
   lpd_pkg::cmd_type     pop_cmd;
   logic                 store_ready;
   logic                 draw_req;
   lpd_pkg::rng_rsp_type rng;

   assign csr_ready = 1'b1;

   lpd_front #(.GRID_SIZE(GRID_SIZE)) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .store_ready (store_ready),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .push_ready  (push_ready)
   );

   lpd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   lpd_twister u_twister (
      .clock      (clock),
      .reset      (reset),
      .seed_load  (csr_valid && csr_ready),
      .seed_value (csr_data),
      .draw_req   (draw_req),
      .rng        (rng)
   );

   lpd_engine #(.GRID_SIZE(GRID_SIZE)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_cmd     (pop_cmd),
      .pop_ready   (pop_ready),
      .store_ready (store_ready),
      .draw_req    (draw_req),
      .rng         (rng),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
